// File: design/fdse_pkg.sv
// Shared types, constants and helper functions of the frame difference span extractor.
package fdse_pkg;

  localparam logic [10:0] MaxWidth  = 11'd1024;
  localparam logic [10:0] MaxHeight = 11'd1024;
  localparam int unsigned QDepth    = 2;

  typedef enum logic [2:0] {
    RegFrameWidth  = 3'd0,
    RegFrameHeight = 3'd1,
    RegMergeGap    = 3'd2,
    RegInterlace   = 3'd3,
    RegFieldParity = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [7:0]  merge_gap;
    logic        interlace_enable;
    logic        field_parity;
  } cfg_t;

  typedef struct packed {
    logic [15:0] new_pixel;
    logic [15:0] shown_pixel;
  } pixel_t;

  typedef struct packed {
    logic [9:0]  span_start_x;
    logic [10:0] span_end_x;
    logic [9:0]  span_row;
    logic [10:0] span_size;
  } span_t;

  typedef struct packed {
    logic       differs;
    logic       last;
    logic [9:0] column;
    logic [9:0] row;
  } entry_t;

  function automatic logic [10:0] eff_dim(input logic [10:0] v, input logic [10:0] max_v);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) begin
      r = 11'd1;
    end else if (v > max_v) begin
      r = max_v;
    end
    return r;
  endfunction

  function automatic logic [9:0] first_row(input cfg_t c);
    logic [9:0] r;
    r = 10'd0;
    if (c.interlace_enable && ({10'd0, c.field_parity} < eff_dim(c.frame_height, MaxHeight))) begin
      r = {9'd0, c.field_parity};
    end
    return r;
  endfunction

endpackage

// File: design/frame_diff_span_extractor.sv
// Top level of the frame difference span extractor: configuration registers and wiring.
// The block compares one new pixel word against the shown pixel each clock and reports
// runs of changed pixels per row as span words. It accepts one pixel word per cycle while
// the span output is not stalled; the front end classifies each word in the cycle it is
// accepted, a two-entry queue decouples it from the span tracker, and the tracker takes
// no queue entry while a finished span waits unread in its output register. An accepted
// closing pixel enters the queue, and its span is registered when the tracker pops it.
// Writing the interlace or parity register restarts the scan at column 0 of the first
// row of the field and drops any open span.
module frame_diff_span_extractor (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [10:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fdse_pkg::pixel_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fdse_pkg::span_t  out_word_o
);
  import fdse_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   restart;
  logic   q_ready;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  entry_t push_entry;
  entry_t pop_entry;

  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFrameWidth:  cfg_d.frame_width  = cfg_wdata_i;
        RegFrameHeight: cfg_d.frame_height = cfg_wdata_i;
        RegMergeGap:    cfg_d.merge_gap    = cfg_wdata_i[7:0];
        RegInterlace: begin
          cfg_d.interlace_enable = cfg_wdata_i[0];
          restart                = 1'b1;
        end
        RegFieldParity: begin
          cfg_d.field_parity = cfg_wdata_i[0];
          restart            = 1'b1;
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width      <= 11'd240;
      cfg_q.frame_height     <= 11'd320;
      cfg_q.merge_gap        <= 8'd4;
      cfg_q.interlace_enable <= 1'b0;
      cfg_q.field_parity     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fdse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cfg_next_i (cfg_d),
    .restart_i  (restart),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  fdse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .ready_o      (q_ready),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_entry_o  (pop_entry)
  );

  fdse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .restart_i   (restart),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.span_size ==
                     out_word_o.span_end_x - {1'b0, out_word_o.span_start_x}))
    else $error("Span size does not match its end and start.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.span_end_x > {1'b0, out_word_o.span_start_x}))
    else $error("Span word is empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("Input stalled while the queue is empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("Queue popped while empty.");

endmodule

// File: design/fdse_front.sv
// Front end: accepts pixel words, compares them and tracks the scan position.
module fdse_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fdse_pkg::cfg_t  cfg_i,
  input  fdse_pkg::cfg_t  cfg_next_i,
  input  logic            restart_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fdse_pkg::pixel_t in_word_i,
  input  logic            q_ready_i,
  output logic            q_push_o,
  output fdse_pkg::entry_t q_entry_o
);
  import fdse_pkg::*;

  logic [9:0]  column_q, column_d;
  logic [9:0]  row_q, row_d;
  logic [10:0] col_inc;
  logic [10:0] row_inc;
  logic [10:0] width;
  logic [10:0] height;
  logic        last;
  logic        accept;

  assign width   = eff_dim(cfg_i.frame_width, MaxWidth);
  assign height  = eff_dim(cfg_i.frame_height, MaxHeight);
  assign col_inc = {1'b0, column_q} + 11'd1;
  assign row_inc = {1'b0, row_q} + (cfg_i.interlace_enable ? 11'd2 : 11'd1);
  assign last    = (col_inc >= width);

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign q_push_o   = accept;

  always_comb begin
    q_entry_o.differs = (in_word_i.new_pixel != in_word_i.shown_pixel);
    q_entry_o.last    = last;
    q_entry_o.column  = column_q;
    q_entry_o.row     = row_q;
  end

  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    if (restart_i) begin
      column_d = 10'd0;
      row_d    = first_row(cfg_next_i);
    end else if (accept) begin
      if (last) begin
        column_d = 10'd0;
        if (row_inc >= height) begin
          row_d = first_row(cfg_i);
        end else begin
          row_d = row_inc[9:0];
        end
      end else begin
        column_d = col_inc[9:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= 10'd0;
      row_q    <= 10'd0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

endmodule

// File: design/fdse_queue.sv
// Two-entry queue between the front end and the span tracker.
module fdse_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fdse_pkg::entry_t push_entry_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output fdse_pkg::entry_t pop_entry_o
);
  import fdse_pkg::*;

  entry_t     mem_q [QDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign ready_o     = (count_q != 2'(QDepth));
  assign valid_o     = (count_q != 2'd0);
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: design/fdse_back.sv
// Back end: tracks the open span and holds the output word register.
module fdse_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fdse_pkg::cfg_t   cfg_i,
  input  logic             restart_i,
  input  logic             q_valid_i,
  input  fdse_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fdse_pkg::span_t  out_word_o
);
  import fdse_pkg::*;

  logic        open_q, open_d;
  logic [9:0]  start_q, start_d;
  logic [10:0] end_q, end_d;
  logic [7:0]  gap_q, gap_d;
  logic        out_valid_q, out_valid_d;
  span_t       out_word_q, out_word_d;
  logic        emit;

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    open_d      = open_q;
    start_d     = start_q;
    end_d       = end_q;
    gap_d       = gap_q;
    emit        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    if (restart_i) begin
      open_d  = 1'b0;
      start_d = 10'd0;
      end_d   = 11'd0;
      gap_d   = 8'd0;
    end else if (q_pop_o) begin
      if (q_entry_i.differs) begin
        if (!open_q) begin
          open_d  = 1'b1;
          start_d = q_entry_i.column;
        end
        end_d = {1'b0, q_entry_i.column} + 11'd1;
        gap_d = 8'd0;
      end else if (open_q) begin
        if (gap_q >= cfg_i.merge_gap) begin
          emit = 1'b1;
        end else begin
          gap_d = gap_q + 8'd1;
        end
      end
      if (q_entry_i.last && open_d) begin
        emit = 1'b1;
      end
      if (emit) begin
        open_d                  = 1'b0;
        gap_d                   = 8'd0;
        out_valid_d             = 1'b1;
        out_word_d.span_start_x = start_d;
        out_word_d.span_end_x   = end_d;
        out_word_d.span_row     = q_entry_i.row;
        out_word_d.span_size    = end_d - {1'b0, start_d};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      start_q     <= 10'd0;
      end_q       <= 11'd0;
      gap_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      open_q      <= open_d;
      start_q     <= start_d;
      end_q       <= end_d;
      gap_q       <= gap_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
